// ===== hw/rtl/pid_position_incremental_unit_defines.svh =====
// ---------------------------------------------------------------------------
// PID unit assertion macros
// Shared concurrent assertion forms, clocked on i_clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef PID_POSITION_INCREMENTAL_UNIT_DEFINES_SVH
`define PID_POSITION_INCREMENTAL_UNIT_DEFINES_SVH

// same-cycle implication
`define PPI_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PPI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ppi_pkg.sv =====
// ---------------------------------------------------------------------------
// ppi_pkg
// Types, codes, microprogram and helper functions of the PID unit.
// ---------------------------------------------------------------------------
`default_nettype none

package ppi_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DW        = 32;
    localparam int AW        = 64;
    localparam int CFG_IDX_W = 3;
    localparam int PC_W      = 5;
    localparam int UC_DEPTH  = 18;

    localparam logic [CFG_IDX_W-1:0] REG_MODE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT = 3'd6;

    localparam logic MODE_POS    = 1'b0;
    localparam logic MODE_INC    = 1'b1;
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_CLEAR  = 1'b1;

    localparam logic [1:0] CLAMP_NONE = 2'd0;
    localparam logic [1:0] CLAMP_HIGH = 2'd1;
    localparam logic [1:0] CLAMP_LOW  = 2'd2;

    localparam logic [PC_W-1:0] PC_ERR   = 5'd0;
    localparam logic [PC_W-1:0] PC_INC   = 5'd10;
    localparam logic [PC_W-1:0] PC_CLEAR = 5'd17;

    typedef enum logic [2:0] {A_NGD, A_K08, A_K02, A_GP, A_GI} t_asel;
    typedef enum logic [2:0] {B_DIFF, B_TERM, B_DF, B_ERR, B_ESUM, B_DE} t_bsel;
    typedef enum logic [2:0] {
        ACC_HOLD, ACC_LD_PROD, ACC_ADD_PROD, ACC_ADD_PROD_SAT, ACC_LD_LAST, ACC_ADD_DF
    } t_acc;
    typedef enum logic [3:0] {
        WR_NONE, WR_ERR, WR_POS_PREP, WR_INC_PREP, WR_TERM,
        WR_DF_PROD, WR_DF_ACC, WR_FINISH, WR_CLEAR
    } t_wr;
    typedef enum logic [1:0] {J_NEXT, J_MODE, J_END} t_jmp;

    typedef struct packed {
        t_asel           asel;
        t_bsel           bsel;
        logic            mul;
        t_acc            acc;
        t_wr             wr;
        t_jmp            jmp;
        logic [PC_W-1:0] target;
    } t_uword;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] gain_p;
        logic signed [31:0] gain_i;
        logic signed [31:0] gain_d;
        logic signed [31:0] out_min;
        logic signed [31:0] out_max;
        logic [30:0]        integ_limit;
    } t_cfg;

    typedef struct packed {
        logic   load;
        logic   fire;
        t_uword uw;
    } t_dp_ctl;

    function automatic logic signed [AW-1:0] sx64(input logic signed [DW-1:0] v);
        return {{(AW-DW){v[DW-1]}}, v};
    endfunction

    function automatic logic signed [DW-1:0] sat32(input logic signed [AW-1:0] v);
        logic signed [DW-1:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[DW-1:0];
        end
        return r;
    endfunction

    function automatic t_uword uw_mk(input t_asel a, input t_bsel b, input logic m,
                                     input t_acc c, input t_wr w, input t_jmp j,
                                     input logic [PC_W-1:0] t);
        t_uword u;
        u.asel   = a;
        u.bsel   = b;
        u.mul    = m;
        u.acc    = c;
        u.wr     = w;
        u.jmp    = j;
        u.target = t;
        return u;
    endfunction

    // microprogram: positional at PC_ERR, incremental branch at PC_INC, clear at PC_CLEAR
    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword u;
        unique case (pc)
            5'd0:  u = uw_mk(A_GP,  B_ERR,  1'b0, ACC_HOLD,         WR_ERR,      J_MODE, PC_INC);
            5'd1:  u = uw_mk(A_GP,  B_ERR,  1'b0, ACC_HOLD,         WR_POS_PREP, J_NEXT, PC_ERR);
            5'd2:  u = uw_mk(A_NGD, B_DIFF, 1'b1, ACC_HOLD,         WR_NONE,     J_NEXT, PC_ERR);
            5'd3:  u = uw_mk(A_K08, B_DF,   1'b1, ACC_HOLD,         WR_TERM,     J_NEXT, PC_ERR);
            5'd4:  u = uw_mk(A_K02, B_TERM, 1'b1, ACC_LD_PROD,      WR_NONE,     J_NEXT, PC_ERR);
            5'd5:  u = uw_mk(A_GP,  B_ERR,  1'b1, ACC_ADD_PROD,     WR_NONE,     J_NEXT, PC_ERR);
            5'd6:  u = uw_mk(A_GI,  B_ESUM, 1'b1, ACC_LD_PROD,      WR_DF_ACC,   J_NEXT, PC_ERR);
            5'd7:  u = uw_mk(A_GP,  B_ERR,  1'b0, ACC_ADD_PROD,     WR_NONE,     J_NEXT, PC_ERR);
            5'd8:  u = uw_mk(A_GP,  B_ERR,  1'b0, ACC_ADD_DF,       WR_NONE,     J_NEXT, PC_ERR);
            5'd9:  u = uw_mk(A_GP,  B_ERR,  1'b0, ACC_HOLD,         WR_FINISH,   J_END,  PC_ERR);
            5'd10: u = uw_mk(A_GP,  B_ERR,  1'b0, ACC_HOLD,         WR_INC_PREP, J_NEXT, PC_ERR);
            5'd11: u = uw_mk(A_NGD, B_DIFF, 1'b1, ACC_HOLD,         WR_NONE,     J_NEXT, PC_ERR);
            5'd12: u = uw_mk(A_GP,  B_DE,   1'b1, ACC_LD_LAST,      WR_DF_PROD,  J_NEXT, PC_ERR);
            5'd13: u = uw_mk(A_GI,  B_ERR,  1'b1, ACC_ADD_PROD_SAT, WR_NONE,     J_NEXT, PC_ERR);
            5'd14: u = uw_mk(A_GP,  B_ERR,  1'b0, ACC_ADD_PROD_SAT, WR_NONE,     J_NEXT, PC_ERR);
            5'd15: u = uw_mk(A_GP,  B_ERR,  1'b0, ACC_ADD_DF,       WR_NONE,     J_NEXT, PC_ERR);
            5'd16: u = uw_mk(A_GP,  B_ERR,  1'b0, ACC_HOLD,         WR_FINISH,   J_END,  PC_ERR);
            5'd17: u = uw_mk(A_GP,  B_ERR,  1'b0, ACC_HOLD,         WR_CLEAR,    J_END,  PC_ERR);
            default: u = uw_mk(A_GP, B_ERR, 1'b0, ACC_HOLD,         WR_NONE,     J_END,  PC_ERR);
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ppi_datapath.sv =====
// ---------------------------------------------------------------------------
// ppi_datapath
// Shared multiplier, accumulator, controller history and output clamp,
// driven one control word per cycle by the sequencer; a word acts only while its fire bit is set.
// ---------------------------------------------------------------------------
`default_nettype none

module ppi_datapath #(
    parameter int FRAC_BITS = ppi_pkg::FRAC_BITS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire ppi_pkg::t_dp_ctl   i_ctl,
    input  wire ppi_pkg::t_cfg      i_cfg,
    input  wire logic signed [31:0] i_setpoint,
    input  wire logic signed [31:0] i_measured,
    output logic signed [31:0]      o_res_drive,
    output logic [1:0]              o_res_clamp
);

    localparam int AW = ppi_pkg::AW;
    localparam longint K08_L = ((longint'(8) <<< FRAC_BITS) + 5) / 10;
    localparam longint K02_L = (longint'(1) <<< FRAC_BITS) - K08_L;
    localparam logic signed [32:0] K08 = 33'(K08_L);
    localparam logic signed [32:0] K02 = 33'(K02_L);
    localparam logic signed [AW-1:0] HALF = 64'(longint'(1) <<< (FRAC_BITS - 1));

    ppi_pkg::t_uword uw;

    logic signed [31:0] r_sp, n_sp, r_ms, n_ms;
    logic signed [31:0] r_err, n_err, r_diff, n_diff, r_de, n_de, r_term, n_term;
    logic signed [AW-1:0] r_prod, n_prod, r_acc, n_acc;
    logic signed [31:0] r_curr_meas, n_curr_meas, r_prev_meas, n_prev_meas;
    logic signed [31:0] r_prev2_meas, n_prev2_meas, r_prev_err, n_prev_err;
    logic signed [31:0] r_err_sum, n_err_sum, r_deriv_filt, n_deriv_filt;
    logic signed [31:0] r_last_drive, n_last_drive;

    logic signed [32:0]   mul_a;
    logic signed [31:0]   mul_b;
    logic signed [64:0]   mul_p;
    logic signed [AW-1:0] prod_q;
    logic signed [AW-1:0] esum_raw, lim64, d2_raw;
    logic signed [31:0]   esum_clamped;
    logic signed [31:0]   clamped;
    logic [1:0]           clamp_code;

    assign uw = i_ctl.uw;

    always_comb begin
        unique case (uw.asel)
            ppi_pkg::A_NGD: mul_a = -{i_cfg.gain_d[31], i_cfg.gain_d};
            ppi_pkg::A_K08: mul_a = K08;
            ppi_pkg::A_K02: mul_a = K02;
            ppi_pkg::A_GP:  mul_a = {i_cfg.gain_p[31], i_cfg.gain_p};
            ppi_pkg::A_GI:  mul_a = {i_cfg.gain_i[31], i_cfg.gain_i};
            default:        mul_a = '0;
        endcase
        unique case (uw.bsel)
            ppi_pkg::B_DIFF: mul_b = r_diff;
            ppi_pkg::B_TERM: mul_b = r_term;
            ppi_pkg::B_DF:   mul_b = r_deriv_filt;
            ppi_pkg::B_ERR:  mul_b = r_err;
            ppi_pkg::B_ESUM: mul_b = r_err_sum;
            ppi_pkg::B_DE:   mul_b = r_de;
            default:         mul_b = '0;
        endcase
    end

    assign mul_p  = mul_a * mul_b;
    assign prod_q = r_prod >>> FRAC_BITS;

    assign esum_raw = ppi_pkg::sx64(r_err_sum) + ppi_pkg::sx64(r_err);
    assign lim64    = {{(AW-31){1'b0}}, i_cfg.integ_limit};
    assign d2_raw   = ppi_pkg::sx64(r_ms) - (ppi_pkg::sx64(r_curr_meas) <<< 1)
                    + ppi_pkg::sx64(r_prev_meas);

    always_comb begin
        if (esum_raw > lim64) begin
            esum_clamped = lim64[31:0];
        end else if (esum_raw < -lim64) begin
            esum_clamped = 32'(-lim64);
        end else begin
            esum_clamped = esum_raw[31:0];
        end
    end

    // upper clamp wins when the limits are inverted
    always_comb begin
        if (r_acc > ppi_pkg::sx64(i_cfg.out_max)) begin
            clamped    = i_cfg.out_max;
            clamp_code = ppi_pkg::CLAMP_HIGH;
        end else if (r_acc < ppi_pkg::sx64(i_cfg.out_min)) begin
            clamped    = i_cfg.out_min;
            clamp_code = ppi_pkg::CLAMP_LOW;
        end else begin
            clamped    = r_acc[31:0];
            clamp_code = ppi_pkg::CLAMP_NONE;
        end
    end

    assign o_res_drive = (uw.wr == ppi_pkg::WR_CLEAR) ? '0 : clamped;
    assign o_res_clamp = (uw.wr == ppi_pkg::WR_CLEAR) ? ppi_pkg::CLAMP_NONE : clamp_code;

    always_comb begin
        n_sp = r_sp;   n_ms = r_ms;
        n_err = r_err; n_diff = r_diff; n_de = r_de; n_term = r_term;
        n_prod = r_prod; n_acc = r_acc;
        n_curr_meas = r_curr_meas; n_prev_meas = r_prev_meas;
        n_prev2_meas = r_prev2_meas; n_prev_err = r_prev_err;
        n_err_sum = r_err_sum; n_deriv_filt = r_deriv_filt;
        n_last_drive = r_last_drive;

        if (i_ctl.load) begin
            n_sp = i_setpoint;
            n_ms = i_measured;
        end

        if (i_ctl.fire) begin
            if (uw.mul) begin
                n_prod = mul_p[AW-1:0] + HALF;
            end

            unique case (uw.acc)
                ppi_pkg::ACC_HOLD:         n_acc = r_acc;
                ppi_pkg::ACC_LD_PROD:      n_acc = prod_q;
                ppi_pkg::ACC_ADD_PROD:     n_acc = r_acc + prod_q;
                ppi_pkg::ACC_ADD_PROD_SAT: n_acc = r_acc + ppi_pkg::sx64(ppi_pkg::sat32(prod_q));
                ppi_pkg::ACC_LD_LAST:      n_acc = ppi_pkg::sx64(r_last_drive);
                ppi_pkg::ACC_ADD_DF:       n_acc = r_acc + ppi_pkg::sx64(r_deriv_filt);
                default:                   n_acc = r_acc;
            endcase

            unique case (uw.wr)
                ppi_pkg::WR_NONE: ;
                ppi_pkg::WR_ERR: begin
                    n_err = ppi_pkg::sat32(ppi_pkg::sx64(r_sp) - ppi_pkg::sx64(r_ms));
                end
                ppi_pkg::WR_POS_PREP: begin
                    n_diff    = ppi_pkg::sat32(ppi_pkg::sx64(r_ms)
                                               - ppi_pkg::sx64(r_curr_meas));
                    n_err_sum = esum_clamped;
                end
                ppi_pkg::WR_INC_PREP: begin
                    n_diff = ppi_pkg::sat32(d2_raw);
                    n_de   = ppi_pkg::sat32(ppi_pkg::sx64(r_err) - ppi_pkg::sx64(r_prev_err));
                end
                ppi_pkg::WR_TERM:    n_term = ppi_pkg::sat32(prod_q);
                ppi_pkg::WR_DF_PROD: n_deriv_filt = ppi_pkg::sat32(prod_q);
                ppi_pkg::WR_DF_ACC:  n_deriv_filt = ppi_pkg::sat32(r_acc);
                ppi_pkg::WR_FINISH: begin
                    n_last_drive = clamped;
                    n_prev_meas  = r_curr_meas;
                    n_curr_meas  = r_ms;
                    n_prev_err   = r_err;
                    if (i_cfg.mode == ppi_pkg::MODE_INC) begin
                        n_prev2_meas = r_prev_meas;
                    end
                end
                ppi_pkg::WR_CLEAR: begin
                    n_curr_meas  = '0;
                    n_prev_meas  = '0;
                    n_prev2_meas = '0;
                    n_prev_err   = '0;
                    n_err_sum    = '0;
                    n_deriv_filt = '0;
                    n_last_drive = '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_sp   <= n_sp;
        r_ms   <= n_ms;
        r_err  <= n_err;
        r_diff <= n_diff;
        r_de   <= n_de;
        r_term <= n_term;
        r_prod <= n_prod;
        r_acc  <= n_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_curr_meas  <= '0;
            r_prev_meas  <= '0;
            r_prev2_meas <= '0;
            r_prev_err   <= '0;
            r_err_sum    <= '0;
            r_deriv_filt <= '0;
            r_last_drive <= '0;
        end else begin
            r_curr_meas  <= n_curr_meas;
            r_prev_meas  <= n_prev_meas;
            r_prev2_meas <= n_prev2_meas;
            r_prev_err   <= n_prev_err;
            r_err_sum    <= n_err_sum;
            r_deriv_filt <= n_deriv_filt;
            r_last_drive <= n_last_drive;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/pid_position_incremental_unit.sv =====
// ---------------------------------------------------------------------------
// pid_position_incremental_unit
// PID regulator, positional or incremental form, signed fixed point.
// ---------------------------------------------------------------------------
// One item in, one drive value out. A control sample in positional form
// runs the microprogram from PC_ERR straight on, in incremental form it takes
// the branch at PC_INC, and a clear item runs only the step at PC_CLEAR; the
// input is taken again the cycle after the result is written, so no new item
// is accepted while one is in progress. The microprogram steps all products
// through one shared 33x32 multiplier and one accumulator. A finished result sits in an output
// register and does not block the next item; only if it is still unread when
// the following result is due does the sequencer wait.
`default_nettype none
`include "pid_position_incremental_unit_defines.svh"

module pid_position_incremental_unit #(
    parameter int FRAC_BITS = ppi_pkg::FRAC_BITS
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic                            i_kind,
    input  wire logic signed [31:0]              i_setpoint,
    input  wire logic signed [31:0]              i_measured,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic signed [31:0]                   o_drive,
    output logic [1:0]                           o_clamp_state,
    input  wire logic                            i_cfg_we,
    input  wire logic [ppi_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [31:0]                     i_cfg_data
);

    localparam int PC_W = ppi_pkg::PC_W;
    localparam longint OUT_LIM_L  = longint'(100) <<< FRAC_BITS;
    localparam longint INTEG_FULL = longint'(1000) <<< FRAC_BITS;
    localparam logic signed [31:0] OUT_MAX_RST = 32'(OUT_LIM_L);
    localparam logic signed [31:0] OUT_MIN_RST = 32'(-OUT_LIM_L);
    localparam logic [30:0] INTEG_RST =
        (INTEG_FULL > longint'(32'h7FFF_FFFF)) ? 31'h7FFF_FFFF : 31'(INTEG_FULL);

    ppi_pkg::t_cfg    r_cfg, n_cfg;
    ppi_pkg::t_uword  uw;
    ppi_pkg::t_dp_ctl dp_ctl;

    logic            r_busy, n_busy;
    logic [PC_W-1:0] r_pc, n_pc;
    logic            r_out_valid, n_out_valid;
    logic signed [31:0] r_drive, n_drive;
    logic [1:0]      r_clamp, n_clamp;

    logic accept, out_free, fin, fire;
    logic signed [31:0] res_drive;
    logic [1:0]      res_clamp;

    assign uw       = ppi_pkg::ucode(r_pc);
    assign accept   = i_valid && !r_busy;
    assign out_free = !r_out_valid || !i_stall;
    assign fin      = (uw.jmp == ppi_pkg::J_END);
    assign fire     = r_busy && (!fin || out_free);

    assign dp_ctl.load = accept;
    assign dp_ctl.fire = fire;
    assign dp_ctl.uw   = uw;

    ppi_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (dp_ctl),
        .i_cfg       (r_cfg),
        .i_setpoint  (i_setpoint),
        .i_measured  (i_measured),
        .o_res_drive (res_drive),
        .o_res_clamp (res_clamp)
    );

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ppi_pkg::REG_MODE:        n_cfg.mode        = i_cfg_data[0];
                ppi_pkg::REG_GAIN_P:      n_cfg.gain_p      = i_cfg_data;
                ppi_pkg::REG_GAIN_I:      n_cfg.gain_i      = i_cfg_data;
                ppi_pkg::REG_GAIN_D:      n_cfg.gain_d      = i_cfg_data;
                ppi_pkg::REG_OUT_MIN:     n_cfg.out_min     = i_cfg_data;
                ppi_pkg::REG_OUT_MAX:     n_cfg.out_max     = i_cfg_data;
                ppi_pkg::REG_INTEG_LIMIT: n_cfg.integ_limit = i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // sequencer: step counter with conditional jumps
    always_comb begin
        n_busy = r_busy;
        n_pc   = r_pc;
        if (accept) begin
            n_busy = 1'b1;
            n_pc   = (i_kind == ppi_pkg::KIND_CLEAR) ? ppi_pkg::PC_CLEAR : ppi_pkg::PC_ERR;
        end else if (fire) begin
            unique case (uw.jmp)
                ppi_pkg::J_NEXT: n_pc = r_pc + PC_W'(1);
                ppi_pkg::J_MODE: begin
                    n_pc = (r_cfg.mode == ppi_pkg::MODE_INC) ? uw.target : r_pc + PC_W'(1);
                end
                ppi_pkg::J_END:  n_busy = 1'b0;
                default:         n_busy = 1'b0;
            endcase
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_drive     = r_drive;
        n_clamp     = r_clamp;
        if (fire && fin) begin
            n_out_valid = 1'b1;
            n_drive     = res_drive;
            n_clamp     = res_clamp;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy            <= 1'b0;
            r_pc              <= ppi_pkg::PC_ERR;
            r_out_valid       <= 1'b0;
            r_cfg.mode        <= ppi_pkg::MODE_INC;
            r_cfg.gain_p      <= '0;
            r_cfg.gain_i      <= '0;
            r_cfg.gain_d      <= '0;
            r_cfg.out_min     <= OUT_MIN_RST;
            r_cfg.out_max     <= OUT_MAX_RST;
            r_cfg.integ_limit <= INTEG_RST;
        end else begin
            r_busy      <= n_busy;
            r_pc        <= n_pc;
            r_out_valid <= n_out_valid;
            r_cfg       <= n_cfg;
        end
    end

    always_ff @(posedge i_clk) begin
        r_drive <= n_drive;
        r_clamp <= n_clamp;
    end

    assign o_stall       = r_busy;
    assign o_valid       = r_out_valid;
    assign o_drive       = r_drive;
    assign o_clamp_state = r_clamp;

    `PPI_ASSERT_NEXT(a_finish_sets_valid, fire && fin, o_valid, "finished item not presented")
    `PPI_ASSERT_NEXT(a_accept_entry, accept, r_busy && (r_pc == ppi_pkg::PC_ERR || r_pc == ppi_pkg::PC_CLEAR), "bad program entry")
    `PPI_ASSERT_NEXT(a_hold_on_full_out, r_busy && fin && r_out_valid && i_stall, r_busy && $stable(r_pc), "sequencer ran past an unread result")
    `PPI_ASSERT_IMPL(a_clamp_code, o_valid, o_clamp_state == ppi_pkg::CLAMP_NONE || o_clamp_state == ppi_pkg::CLAMP_HIGH || o_clamp_state == ppi_pkg::CLAMP_LOW, "illegal clamp code")

endmodule

`default_nettype wire

// ===== bench/tb_pid_position_incremental_unit.sv =====
// ---------------------------------------------------------------------------
// tb_pid_position_incremental_unit
// Self-checking bench for the PID unit. A queued driver feeds samples and
// clear items with random gaps. A predictor in the bench computes each
// drive value and clamp state per accepted item. The monitor applies random
// backpressure, including one long hold, and checks every result in order.
// Configuration is rewritten between phases, only while the unit is idle.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_pid_position_incremental_unit;

    localparam int     FB             = ppi_pkg::FRAC_BITS;
    localparam int     ONE            = 1 << FB;
    localparam longint Q_MAX          = 64'sd2147483647;
    localparam longint Q_MIN          = -64'sd2147483648;
    localparam longint K08            = ((longint'(8) <<< FB) + 5) / 10;
    localparam longint K02            = (longint'(1) <<< FB) - K08;
    localparam int     V_MAX          = 32'sh7FFF_FFFF;
    localparam int     V_MIN          = 32'sh8000_0000;
    localparam int     HOLD_AT        = 120;
    localparam int     HOLD_LEN       = 400;
    localparam int     WATCHDOG_LIMIT = 5000;
    localparam int     RAND_PHASES    = 10;
    localparam int     PHASE_ITEMS    = 80;

    typedef struct {
        logic               kind;
        logic signed [31:0] setpoint;
        logic signed [31:0] measured;
    } t_pid_sample;

    typedef struct {
        logic signed [31:0] drive;
        logic [1:0]         clamp;
    } t_pid_result;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          s_valid = 1'b0;
    logic                          s_stall;
    logic                          s_kind = 1'b0;
    logic signed [31:0]            s_setpoint = '0;
    logic signed [31:0]            s_measured = '0;
    logic                          r_valid;
    logic                          r_stall = 1'b0;
    logic signed [31:0]            r_drive;
    logic [1:0]                    r_clamp;
    logic                          cfg_we = 1'b0;
    logic [ppi_pkg::CFG_IDX_W-1:0] cfg_idx = ppi_pkg::REG_MODE;
    logic [31:0]                   cfg_data = '0;

    t_pid_sample   sample_q[$];
    t_pid_result   drive_q[$];
    t_pid_sample   nxt;
    t_pid_result   want;
    ppi_pkg::t_cfg m_cfg;
    longint        h_curr, h_prev, h_prev2, h_err, h_esum, h_df, h_last;
    int            err_count = 0;
    int            rx_count = 0;
    int            gap_left = 0;
    int            stall_left = 0;
    int            hold_left = 0;
    bit            held = 1'b0;
    bit            tx_quiet = 1'b0;
    bit            rx_quiet = 1'b0;
    int            idle_cycles = 0;

    pid_position_incremental_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_valid),
        .o_stall       (s_stall),
        .i_kind        (s_kind),
        .i_setpoint    (s_setpoint),
        .i_measured    (s_measured),
        .o_valid       (r_valid),
        .i_stall       (r_stall),
        .o_drive       (r_drive),
        .o_clamp_state (r_clamp),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ---------------- predictor ----------------

    function automatic longint sat_q(input longint v);
        if (v > Q_MAX) return Q_MAX;
        if (v < Q_MIN) return Q_MIN;
        return v;
    endfunction

    // exact product, round half up, then floor shift
    function automatic longint mul_q(input longint a, input longint b);
        return (a * b + (longint'(1) <<< (FB - 1))) >>> FB;
    endfunction

    function automatic t_pid_result pid_predict(input logic kind,
                                                input logic signed [31:0] sp_in,
                                                input logic signed [31:0] ms_in);
        longint      sp, ms, err, sum, lim, dm, term, de, d2, gp, gi, ngd, omin, omax;
        t_pid_result res;
        sp   = sp_in;
        ms   = ms_in;
        gp   = $signed(m_cfg.gain_p);
        gi   = $signed(m_cfg.gain_i);
        ngd  = $signed(m_cfg.gain_d);
        ngd  = -ngd;
        omin = $signed(m_cfg.out_min);
        omax = $signed(m_cfg.out_max);
        lim  = longint'(m_cfg.integ_limit);
        res.clamp = ppi_pkg::CLAMP_NONE;
        if (kind == ppi_pkg::KIND_CLEAR) begin
            h_curr = 0; h_prev = 0; h_prev2 = 0;
            h_err = 0; h_esum = 0; h_df = 0; h_last = 0;
            res.drive = '0;
            return res;
        end
        err = sat_q(sp - ms);
        if (m_cfg.mode == ppi_pkg::MODE_POS) begin
            h_prev = h_curr;
            h_curr = ms;
            h_err  = err;
            h_esum = h_esum + err;
            if (h_esum > lim) begin
                h_esum = lim;
            end else if (h_esum < -lim) begin
                h_esum = -lim;
            end
            dm   = sat_q(h_curr - h_prev);
            term = sat_q(mul_q(ngd, dm));
            h_df = sat_q(mul_q(K02, term) + mul_q(K08, h_df));
            sum  = mul_q(gp, err) + mul_q(gi, h_esum) + h_df;
        end else begin
            h_prev2 = h_prev;
            h_prev  = h_curr;
            h_curr  = ms;
            de      = sat_q(err - h_err);
            h_err   = err;
            d2      = sat_q(h_curr - 2 * h_prev + h_prev2);
            h_df    = sat_q(mul_q(ngd, d2));
            sum     = h_last + sat_q(mul_q(gp, de)) + sat_q(mul_q(gi, err)) + h_df;
        end
        // upper clamp wins when the limits are inverted
        if (sum > omax) begin
            sum = omax;
            res.clamp = ppi_pkg::CLAMP_HIGH;
        end else if (sum < omin) begin
            sum = omin;
            res.clamp = ppi_pkg::CLAMP_LOW;
        end
        h_last    = sum;
        res.drive = sum[31:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && cfg_we) begin
            case (cfg_idx)
                ppi_pkg::REG_MODE:        m_cfg.mode        = cfg_data[0];
                ppi_pkg::REG_GAIN_P:      m_cfg.gain_p      = cfg_data;
                ppi_pkg::REG_GAIN_I:      m_cfg.gain_i      = cfg_data;
                ppi_pkg::REG_GAIN_D:      m_cfg.gain_d      = cfg_data;
                ppi_pkg::REG_OUT_MIN:     m_cfg.out_min     = cfg_data;
                ppi_pkg::REG_OUT_MAX:     m_cfg.out_max     = cfg_data;
                ppi_pkg::REG_INTEG_LIMIT: m_cfg.integ_limit = cfg_data[30:0];
                default: ;
            endcase
        end
        if (i_rst_n && s_valid && !s_stall) begin
            drive_q.push_back(pid_predict(s_kind, s_setpoint, s_measured));
        end
    end

    // ---------------- driver ----------------

    function automatic int draw_gap(input bit quiet);
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid  <= 1'b0;
            gap_left <= 0;
        end else if (!s_valid || !s_stall) begin
            if (gap_left > 0) begin
                s_valid  <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (sample_q.size() != 0) begin
                nxt         = sample_q.pop_front();
                s_valid    <= 1'b1;
                s_kind     <= nxt.kind;
                s_setpoint <= nxt.setpoint;
                s_measured <= nxt.measured;
                gap_left   <= draw_gap(tx_quiet);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ---------------- monitor ----------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stall <= 1'b0;
        end else begin
            if (r_valid && !r_stall) begin
                if (drive_q.size() == 0) begin
                    $error("unexpected result: drive %0d clamp_state %0d", r_drive, r_clamp);
                    err_count++;
                end else begin
                    want = drive_q.pop_front();
                    if (r_drive !== want.drive) begin
                        $error("drive: expected %0d, got %0d", want.drive, r_drive);
                        err_count++;
                    end
                    if (r_clamp !== want.clamp) begin
                        $error("clamp_state: expected %0d, got %0d", want.clamp, r_clamp);
                        err_count++;
                    end
                end
                rx_count++;
            end
            if (hold_left > 0) begin
                r_stall   <= 1'b1;
                hold_left <= hold_left - 1;
            end else if (!held && rx_count >= HOLD_AT) begin
                // long hold-off so the unit backs up and stalls its input
                held      <= 1'b1;
                hold_left <= HOLD_LEN;
                r_stall   <= 1'b1;
            end else if (stall_left > 0) begin
                r_stall    <= 1'b1;
                stall_left <= stall_left - 1;
            end else if (!rx_quiet && $urandom_range(0, 3) == 0) begin
                r_stall    <= 1'b1;
                stall_left <= draw_gap(1'b0);
            end else begin
                r_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_valid && !s_stall) || (r_valid && !r_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------- stimulus ----------------

    function automatic ppi_pkg::t_cfg mk_cfg(input logic m, input int gp, input int gi,
                                             input int gd, input int mn, input int mx,
                                             input int lim);
        ppi_pkg::t_cfg c;
        c.mode        = m;
        c.gain_p      = gp;
        c.gain_i      = gi;
        c.gain_d      = gd;
        c.out_min     = mn;
        c.out_max     = mx;
        c.integ_limit = 31'(lim);
        return c;
    endfunction

    function automatic int rand_gain();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return int'($urandom_range(0, 8 * ONE)) - 4 * ONE;
        if (r < 85) return int'($urandom_range(0, ONE / 2)) - ONE / 4;
        return int'($urandom);
    endfunction

    function automatic ppi_pkg::t_cfg rand_cfg();
        ppi_pkg::t_cfg c;
        int            r;
        c.mode   = ($urandom_range(0, 1) == 0) ? ppi_pkg::MODE_POS : ppi_pkg::MODE_INC;
        c.gain_p = rand_gain();
        c.gain_i = rand_gain();
        c.gain_d = rand_gain();
        r = $urandom_range(0, 99);
        if (r < 75) begin
            c.out_min = -int'($urandom_range(ONE, 200 * ONE));
            c.out_max = int'($urandom_range(ONE, 200 * ONE));
        end else if (r < 85) begin
            c.out_min = V_MIN;
            c.out_max = V_MAX;
        end else if (r < 93) begin
            c.out_min = int'($urandom_range(0, 20 * ONE));
            c.out_max = -int'($urandom_range(0, 20 * ONE));
        end else begin
            c.out_min = $urandom;
            c.out_max = $urandom;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            c.integ_limit = 31'($urandom_range(1, 2000 * ONE));
        end else if (r < 80) begin
            c.integ_limit = 31'($urandom_range(1, ONE));
        end else if (r < 90) begin
            c.integ_limit = 31'h7FFF_FFFF;
        end else begin
            c.integ_limit = 31'($urandom);
        end
        return c;
    endfunction

    task automatic write_cfg(input ppi_pkg::t_cfg c);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= ppi_pkg::REG_MODE;
        cfg_data <= {31'd0, c.mode};
        @(posedge i_clk);
        cfg_idx  <= ppi_pkg::REG_GAIN_P;
        cfg_data <= c.gain_p;
        @(posedge i_clk);
        cfg_idx  <= ppi_pkg::REG_GAIN_I;
        cfg_data <= c.gain_i;
        @(posedge i_clk);
        cfg_idx  <= ppi_pkg::REG_GAIN_D;
        cfg_data <= c.gain_d;
        @(posedge i_clk);
        cfg_idx  <= ppi_pkg::REG_OUT_MIN;
        cfg_data <= c.out_min;
        @(posedge i_clk);
        cfg_idx  <= ppi_pkg::REG_OUT_MAX;
        cfg_data <= c.out_max;
        @(posedge i_clk);
        cfg_idx  <= ppi_pkg::REG_INTEG_LIMIT;
        cfg_data <= {1'b0, c.integ_limit};
        @(posedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic push_sample(input logic kind, input int sp, input int ms);
        t_pid_sample s;
        s.kind     = kind;
        s.setpoint = sp;
        s.measured = ms;
        sample_q.push_back(s);
    endtask

    // wait on settled state, then let the sequencer go idle
    task automatic drain();
        do begin
            @(negedge i_clk);
        end while (sample_q.size() != 0 || s_valid || drive_q.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // mostly a tracking loop with random setpoint moves, some noise and clears
    task automatic gen_phase(input int n);
        int sp, ms, r, step;
        sp = int'($urandom_range(0, 400 * ONE)) - 200 * ONE;
        ms = int'($urandom_range(0, 400 * ONE)) - 200 * ONE;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 4) begin
                push_sample(ppi_pkg::KIND_CLEAR, $urandom, $urandom);
            end else if (r < 14) begin
                push_sample(ppi_pkg::KIND_SAMPLE, $urandom, $urandom);
            end else begin
                if ($urandom_range(0, 15) == 0) begin
                    sp = int'($urandom_range(0, 400 * ONE)) - 200 * ONE;
                end
                step = int'($urandom_range(0, 8 * ONE)) - 4 * ONE;
                ms   = ms + (sp - ms) / 8 + step;
                push_sample(ppi_pkg::KIND_SAMPLE, sp, ms);
            end
        end
    endtask

    initial begin
        m_cfg = mk_cfg(ppi_pkg::MODE_INC, 0, 0, 0, -100 * ONE, 100 * ONE, 1000 * ONE);
        h_curr = 0; h_prev = 0; h_prev2 = 0;
        h_err = 0; h_esum = 0; h_df = 0; h_last = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // positional, moderate gains, error saturation both ways, clear
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        write_cfg(mk_cfg(ppi_pkg::MODE_POS, ONE, ONE / 4, 2 * ONE, -100 * ONE, 100 * ONE,
                         1000 * ONE));
        push_sample(ppi_pkg::KIND_SAMPLE, 0, 0);
        push_sample(ppi_pkg::KIND_SAMPLE, V_MAX, V_MIN);
        push_sample(ppi_pkg::KIND_SAMPLE, V_MIN, V_MAX);
        push_sample(ppi_pkg::KIND_SAMPLE, 5 * ONE, ONE);
        push_sample(ppi_pkg::KIND_SAMPLE, 5 * ONE, 2 * ONE);
        push_sample(ppi_pkg::KIND_CLEAR, V_MAX, V_MIN);
        push_sample(ppi_pkg::KIND_SAMPLE, -3 * ONE, 4 * ONE);
        drain();

        // positional, zero integral limit, extreme gains, full output range
        tx_quiet = 1'b0;
        write_cfg(mk_cfg(ppi_pkg::MODE_POS, V_MIN, V_MAX, V_MIN, V_MIN, V_MAX, 0));
        push_sample(ppi_pkg::KIND_SAMPLE, ONE, V_MAX);
        push_sample(ppi_pkg::KIND_SAMPLE, 0, V_MIN);
        push_sample(ppi_pkg::KIND_SAMPLE, V_MAX, 0);
        push_sample(ppi_pkg::KIND_SAMPLE, -1, 1);
        drain();

        // incremental, inverted output limits
        rx_quiet = 1'b0;
        write_cfg(mk_cfg(ppi_pkg::MODE_INC, ONE, ONE / 2, ONE / 4, 10 * ONE, -10 * ONE,
                         1000 * ONE));
        push_sample(ppi_pkg::KIND_SAMPLE, 50 * ONE, 0);
        push_sample(ppi_pkg::KIND_SAMPLE, -50 * ONE, 0);
        push_sample(ppi_pkg::KIND_SAMPLE, 0, 0);
        push_sample(ppi_pkg::KIND_SAMPLE, V_MIN, V_MAX);
        push_sample(ppi_pkg::KIND_CLEAR, 0, 0);
        drain();

        // incremental, extreme gains and limits
        write_cfg(mk_cfg(ppi_pkg::MODE_INC, V_MAX, V_MIN, V_MIN, V_MIN, V_MAX, V_MAX));
        push_sample(ppi_pkg::KIND_SAMPLE, V_MAX, V_MIN);
        push_sample(ppi_pkg::KIND_SAMPLE, V_MIN, V_MAX);
        push_sample(ppi_pkg::KIND_SAMPLE, V_MAX, V_MAX);
        push_sample(ppi_pkg::KIND_SAMPLE, V_MIN, V_MIN);
        push_sample(ppi_pkg::KIND_CLEAR, V_MIN, V_MAX);
        drain();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            write_cfg(rand_cfg());
            gen_phase(PHASE_ITEMS);
            drain();
        end

        repeat (20) @(posedge i_clk);
        if (drive_q.size() != 0) begin
            $error("results never arrived: %0d", drive_q.size());
            err_count++;
        end
        if (err_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire
